// File: hw/rtl/rdq_pkg.sv
// Shared types and constants of the request deque.
`timescale 1ns / 1ps

package rdq_pkg;

    localparam int DESC_W = 16;
    localparam int ARR_W  = 48;
    localparam int POS_W  = 6;
    localparam int CNT_W  = 7;
    localparam int CAP_W  = 7;

    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 120;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [1:0] {
        OP_APPEND    = 2'd0,
        OP_POP_HEAD  = 2'd1,
        OP_POP_TAIL  = 2'd2,
        OP_REMOVE_AT = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef struct packed {
        status_t             status;
        logic [DESC_W-1:0]   removed;
        logic [CNT_W-1:0]    count;
        logic [ARR_W-1:0]    head;
        logic [ARR_W-1:0]    tail;
    } result_t;

endpackage

// File: hw/rtl/rdq_store.sv
// Entry memory: one write port, one read port with registered data.
`timescale 1ns / 1ps

module rdq_store #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/rdq_seq.sv
// Sequencer: decodes a request and walks the entry memory one slot a cycle.
`timescale 1ns / 1ps

module rdq_seq #(
    parameter int DEPTH     = 64,
    parameter int TIME_BITS = 48
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [rdq_pkg::CAP_W-1:0]    cfg_wdata,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  rdq_pkg::opcode_t             req_op,
    input  logic [rdq_pkg::DESC_W-1:0]   req_desc,
    input  logic [rdq_pkg::ARR_W-1:0]    req_arr,
    input  logic [rdq_pkg::POS_W-1:0]    req_pos,
    output logic                         res_valid,
    input  logic                         res_ready,
    output rdq_pkg::result_t             res
);
    import rdq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int TW = TIME_BITS;
    localparam int MW = DESC_W + TW;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_REM_RD,
        S_REM_CAP,
        S_SHIFT,
        S_HEAD,
        S_HEAD_CAP,
        S_TAIL_CAP,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    opcode_t             op_reg, op_next;
    logic [DESC_W-1:0]   desc_reg, desc_next;
    logic [TW-1:0]       arr_reg, arr_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CAP_W-1:0]    cap_reg, cap_next;
    logic [AW-1:0]       idx_reg, idx_next;
    status_t             status_reg, status_next;
    logic [DESC_W-1:0]   removed_reg, removed_next;
    logic [TW-1:0]       head_reg, head_next;
    logic [TW-1:0]       tail_reg, tail_next;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [MW-1:0]       mem_wdata;
    logic [AW-1:0]       mem_raddr;
    logic [MW-1:0]       mem_rdata;
    logic [63:0]         arr_wide;
    logic                is_full;

    rdq_store #(
        .DEPTH (DEPTH),
        .WIDTH (MW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign arr_wide = {16'b0, req_arr};
    assign is_full  = (32'(count_reg) >= 32'(cap_reg)) || (32'(count_reg) >= DEPTH);

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        desc_next    = desc_reg;
        arr_next     = arr_reg;
        pos_next     = pos_reg;
        count_next   = count_reg;
        cap_next     = cfg_we ? cfg_wdata : cap_reg;
        idx_next     = idx_reg;
        status_next  = status_reg;
        removed_next = removed_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        mem_we       = 1'b0;
        mem_waddr    = idx_reg;
        mem_wdata    = mem_rdata;
        mem_raddr    = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next      = req_op;
                    desc_next    = req_desc;
                    arr_next     = arr_wide[TW-1:0];
                    pos_next     = req_pos;
                    status_next  = ST_OK;
                    removed_next = '0;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = S_HEAD;
                if (op_reg == OP_APPEND)
                begin
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = AW'(count_reg);
                        mem_wdata  = {arr_reg, desc_reg};
                        count_next = count_reg + 1'b1;
                    end
                end
                else if (count_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else if (op_reg == OP_POP_HEAD)
                begin
                    idx_next   = '0;
                    state_next = S_REM_RD;
                end
                else if (op_reg == OP_POP_TAIL)
                begin
                    idx_next   = AW'(count_reg - 1'b1);
                    state_next = S_REM_RD;
                end
                else if (32'(pos_reg) >= 32'(count_reg))
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    idx_next   = AW'(pos_reg);
                    state_next = S_REM_RD;
                end
            end
            S_REM_RD:
            begin
                mem_raddr  = idx_reg;
                state_next = S_REM_CAP;
            end
            S_REM_CAP:
            begin
                removed_next = mem_rdata[DESC_W-1:0];
                if (32'(idx_reg) + 32'd1 < 32'(count_reg))
                begin
                    mem_raddr  = idx_reg + 1'b1;
                    state_next = S_SHIFT;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_HEAD;
                end
            end
            S_SHIFT:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = mem_rdata;
                idx_next  = idx_reg + 1'b1;
                if (32'(idx_reg) + 32'd2 < 32'(count_reg))
                begin
                    mem_raddr = AW'(32'(idx_reg) + 32'd2);
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                if (count_reg == '0)
                begin
                    head_next  = '0;
                    tail_next  = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_raddr  = '0;
                    state_next = S_HEAD_CAP;
                end
            end
            S_HEAD_CAP:
            begin
                head_next  = mem_rdata[MW-1:DESC_W];
                mem_raddr  = AW'(count_reg - 1'b1);
                state_next = S_TAIL_CAP;
            end
            S_TAIL_CAP:
            begin
                tail_next  = mem_rdata[MW-1:DESC_W];
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            cap_reg    <= CAP_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            cap_reg    <= cap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        desc_reg    <= desc_next;
        arr_reg     <= arr_next;
        pos_reg     <= pos_next;
        idx_reg     <= idx_next;
        status_reg  <= status_next;
        removed_reg <= removed_next;
        head_reg    <= head_next;
        tail_reg    <= tail_next;
    end

    logic [63:0] head_wide;
    logic [63:0] tail_wide;

    assign head_wide   = 64'(head_reg);
    assign tail_wide   = 64'(tail_reg);

    assign req_ready   = (state_reg == S_IDLE);
    assign res_valid   = (state_reg == S_DONE);
    assign res.status  = status_reg;
    assign res.removed = removed_reg;
    assign res.count   = CNT_W'(count_reg);
    assign res.head    = head_wide[ARR_W-1:0];
    assign res.tail    = tail_wide[ARR_W-1:0];

endmodule

// File: hw/rtl/request_deque_with_indexed_removal.sv
// Top level of the request deque with removal at a position.
//
// Usage: each request on the s_ channel carries an opcode in s_tuser (append,
// remove head, remove tail, remove at position) and descriptor, arrival time
// and position in s_tdata. Exactly one result per request leaves on the m_
// channel: status in m_tuser, removed descriptor, entry count and head and
// tail arrival times in m_tdata. cfg_we with cfg_wdata sets the capacity
// limit; write it only while no request is in flight.
// Flow: each request is checked after acceptance. A removal then reads the
// removed entry and shifts every later entry down, the entry memory shifting
// one slot per cycle through its single read and single write port. Unless
// the queue is then empty, the head and tail arrival times are read from the
// entry memory before the result enters the output register. One request is
// in work at a time and the next is taken only after its result enters the
// output register.
// Reset empties the queue and sets the capacity limit to 64; memory contents
// are not cleared. When the receiver stalls, the result waits in the output
// register while the next request is already taken and worked on; its result
// is held back until the output register frees.
`timescale 1ns / 1ps

module request_deque_with_indexed_removal #(
    parameter int DEPTH     = 64,
    parameter int TIME_BITS = 48
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rdq_pkg::CAP_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [15:0] descriptor_in, [63:16] arrival_in, [69:64] position, [71:70] zero
    input  logic [rdq_pkg::S_DATA_W-1:0]  s_tdata,
    // [1:0] opcode
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [15:0] removed_descriptor, [22:16] count_out, [70:23] head_arrival,
    // [118:71] tail_arrival, [119] zero
    output logic [rdq_pkg::M_DATA_W-1:0]  m_tdata,
    // [1:0] status
    output logic [1:0]                    m_tuser
);
    import rdq_pkg::*;

    logic     res_valid;
    logic     res_ready;
    result_t  res;
    result_t  out_reg, out_next;
    logic     m_tvalid_reg, m_tvalid_next;

    rdq_seq #(
        .DEPTH     (DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req_op    (opcode_t'(s_tuser)),
        .req_desc  (s_tdata[15:0]),
        .req_arr   (s_tdata[63:16]),
        .req_pos   (s_tdata[69:64]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        out_next      = out_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (res_valid && res_ready)
        begin
            out_next      = res;
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {1'b0, out_reg.tail, out_reg.head, out_reg.count, out_reg.removed};

endmodule
